// ===== rtl/cpbf_pkg.sv =====
// Shared types and constants for the closest pair search core.
package cpbf_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int COORD_W        = 16;
  // Squared distance of two Q12.4 points fits in 34 bits.
  localparam int SQ_W           = 34;
  localparam int ROOT_W         = SQ_W / 2;
  localparam int DIST_W         = 18;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic        [DIST_W-1:0]  min_distance;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic                      no_pair;
    logic                      points_dropped;
  } result_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ISSUE_I,
    ST_ISSUE_J,
    ST_DRAIN,
    ST_ROOT_GO,
    ST_SQRT
  } state_t;

endpackage

// ===== rtl/cpbf_isqrt.sv =====
// Bit-serial floor square root, one result bit per cycle.
module cpbf_isqrt import cpbf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic            active;
  logic [SQ_W-1:0] rem_v;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W:0]   trial;
  logic            take;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign take  = {1'b0, rem_v} >= trial;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= active && !start && bitv[0];
      if (start) begin
        active <= 1'b1;
      end else if (active && bitv[0]) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_v <= value;
      res   <= '0;
      bitv  <= SQ_W'(1) << (SQ_W - 2);
    end else if (active) begin
      if (take) begin
        rem_v <= rem_v - trial[SQ_W-1:0];
        res   <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ===== rtl/closest_pair_brute_force_core.sv =====
// Closest pair of points: load a point set, scan all pairs, emit the nearest one.
//
// Input: a word (point_x, point_y, last_point) is taken at a rising edge with
// start high and busy low; points beyond MAX_POINTS are dropped and reported
// in points_dropped of that set's result. A word with last_point high ends
// the set. With fewer than two points the result (no_pair set) comes in the
// next cycle and busy never rises. Otherwise busy rises and the block scans
// every pair out of the point memory, one pair per cycle over its single read
// port, apart from a fetch of each first point; then the distance pipeline
// drains and the bit-serial square root runs.
// The result appears on result for exactly one cycle with done high; busy is
// low in that cycle, so the next set may start at once. The receiver cannot
// stall. Reset empties the set and returns the block to loading; the point
// memory is not cleared, only entries written in the current set are read.
module closest_pair_brute_force_core import cpbf_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  point_t  point,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef struct packed {
    logic valid;
    logic is_i;
    logic last;
  } tag_t;

  state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic             overflow;
  logic             dropped;
  logic [IDX_W-1:0] i_idx, i_next;
  logic [IDX_W-1:0] j_idx, j_next;

  logic [2*COORD_W-1:0] point_store [MAX_POINTS];
  logic [IDX_W-1:0]     rd_addr;
  logic [2*COORD_W-1:0] rd_data;
  tag_t                 iss, rd_tag;

  logic accept, have_room, mem_we;
  logic [CNT_W-1:0] count_after;

  logic signed [COORD_W-1:0] pi_x, pi_y;

  // distance pipeline
  logic signed [COORD_W-1:0] pj_x, pj_y;
  logic signed [COORD_W:0]   diff_x, diff_y;
  logic [COORD_W-1:0]        abs_x, abs_y;
  logic                      s1_valid, s1_last;
  logic [COORD_W-1:0]        s1_dx, s1_dy;
  logic signed [COORD_W-1:0] s1_ix, s1_iy, s1_jx, s1_jy;
  logic                      s2_valid, s2_last;
  logic [2*COORD_W-1:0]      s2_dx2, s2_dy2;
  logic signed [COORD_W-1:0] s2_ix, s2_iy, s2_jx, s2_jy;
  logic [SQ_W-1:0]           d2;
  logic                      take_best;

  logic                      found;
  logic [SQ_W-1:0]           best_sq;
  logic signed [COORD_W-1:0] best_ix, best_iy, best_jx, best_jy;

  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;

  assign busy        = (state != ST_LOAD);
  assign accept      = start && !busy;
  assign have_room   = count < CNT_W'(MAX_POINTS);
  assign count_after = have_room ? count + 1'b1 : count;
  assign mem_we      = accept && have_room;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i_idx;
    j_next     = j_idx;
    rd_addr    = i_idx;
    iss        = '0;
    sq_start   = 1'b0;
    case (state)
      ST_LOAD: begin
        if (accept && point.last_point && count_after >= CNT_W'(2)) begin
          state_next = ST_ISSUE_I;
          i_next     = '0;
        end
      end
      ST_ISSUE_I: begin
        rd_addr    = i_idx;
        iss.valid  = 1'b1;
        iss.is_i   = 1'b1;
        j_next     = i_idx + 1'b1;
        state_next = ST_ISSUE_J;
      end
      ST_ISSUE_J: begin
        rd_addr   = j_idx;
        iss.valid = 1'b1;
        if (CNT_W'(j_idx) == count - 1'b1) begin
          if (CNT_W'(i_idx) == count - CNT_W'(2)) begin
            iss.last   = 1'b1;
            state_next = ST_DRAIN;
          end else begin
            i_next     = i_idx + 1'b1;
            state_next = ST_ISSUE_I;
          end
        end else begin
          j_next = j_idx + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (s2_valid && s2_last) begin
          state_next = ST_ROOT_GO;
        end
      end
      ST_ROOT_GO: begin
        sq_start   = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_done) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    i_idx <= i_next;
    j_idx <= j_next;
  end

  // ---------------------------------------------------------------- set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      dropped  <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= (accept && point.last_point && count_after < CNT_W'(2)) ||
              (state == ST_SQRT && sq_done);
      if (accept) begin
        if (point.last_point) begin
          if (count_after < CNT_W'(2)) begin
            count    <= '0;
            overflow <= 1'b0;
          end else begin
            count   <= count_after;
            dropped <= overflow || !have_room;
          end
        end else begin
          count    <= count_after;
          overflow <= overflow || !have_room;
        end
      end else if (state == ST_SQRT && sq_done) begin
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && point.last_point && count_after < CNT_W'(2)) begin
      result.min_distance   <= '0;
      result.first_x        <= '0;
      result.first_y        <= '0;
      result.second_x       <= '0;
      result.second_y       <= '0;
      result.no_pair        <= 1'b1;
      result.points_dropped <= overflow || !have_room;
    end else if (state == ST_SQRT && sq_done) begin
      result.min_distance   <= DIST_W'(sq_root);
      result.first_x        <= best_ix;
      result.first_y        <= best_iy;
      result.second_x       <= best_jx;
      result.second_y       <= best_jy;
      result.no_pair        <= 1'b0;
      result.points_dropped <= dropped;
    end
  end

  // ---------------------------------------------------------------- point memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      point_store[count[IDX_W-1:0]] <= {point.point_y, point.point_x};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= point_store[rd_addr];
  end

  // ---------------------------------------------------------------- distance pipeline
  assign pj_x   = rd_data[COORD_W-1:0];
  assign pj_y   = rd_data[2*COORD_W-1:COORD_W];
  assign diff_x = {pi_x[COORD_W-1], pi_x} - {pj_x[COORD_W-1], pj_x};
  assign diff_y = {pi_y[COORD_W-1], pi_y} - {pj_y[COORD_W-1], pj_y};
  assign abs_x  = diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
  assign abs_y  = diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag   <= '0;
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      s2_valid <= 1'b0;
      s2_last  <= 1'b0;
    end else begin
      rd_tag   <= iss;
      s1_valid <= rd_tag.valid && !rd_tag.is_i;
      s1_last  <= rd_tag.last;
      s2_valid <= s1_valid;
      s2_last  <= s1_last;
    end
  end

  // Hold the first point of the pairs in flight; the fetch of a new first
  // point lands after the last pair of the old one has left this stage.
  always_ff @(posedge clk) begin
    if (rd_tag.valid && rd_tag.is_i) begin
      pi_x <= pj_x;
      pi_y <= pj_y;
    end
    s1_dx  <= abs_x;
    s1_dy  <= abs_y;
    s1_ix  <= pi_x;
    s1_iy  <= pi_y;
    s1_jx  <= pj_x;
    s1_jy  <= pj_y;
    s2_dx2 <= s1_dx * s1_dx;
    s2_dy2 <= s1_dy * s1_dy;
    s2_ix  <= s1_ix;
    s2_iy  <= s1_iy;
    s2_jx  <= s1_jx;
    s2_jy  <= s1_jy;
  end

  assign d2        = {2'b00, s2_dx2} + {2'b00, s2_dy2};
  // Replace only on strictly smaller: the first pair in scan order wins ties.
  assign take_best = s2_valid && (!found || d2 < best_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (state == ST_LOAD) begin
      found <= 1'b0;
    end else if (take_best) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_sq <= d2;
      best_ix <= s2_ix;
      best_iy <= s2_iy;
      best_jx <= s2_jx;
      best_jy <= s2_jy;
    end
  end

  cpbf_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (best_sq),
    .done  (sq_done),
    .root  (sq_root)
  );

  // ---------------------------------------------------------------- checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_write_load: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_LOAD)
    else $error("point memory written outside loading");

  a_pipe_scan: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (state == ST_ISSUE_I || state == ST_ISSUE_J || state == ST_DRAIN))
    else $error("pair in flight outside the scan");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_root_found: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> found)
    else $error("square root started with no pair found");

endmodule
